[src/triplet_stdp_weight_update_assert.svh]
// Assertion macros shared by the triplet STDP checker.
// Expects clk and rst_n in scope where a macro is used.
`ifndef TRIPLET_STDP_WEIGHT_UPDATE_ASSERT_SVH
`define TRIPLET_STDP_WEIGHT_UPDATE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TSW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tsw_pkg.sv]
// Types and constants of the triplet STDP weight update block.
// No dependencies; used by tsw_mul, triplet_stdp_weight_update, tsw_checker and testbench.
package tsw_pkg;

    localparam int DIGIT_BITS     = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_BASE_FRAC  = 20;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PRE_DECAY   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_DECAY  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_DECAY  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LTP_GAIN    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LTD_GAIN    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HETERO_GAIN = 3'd5;

    // reset values with CFG_BASE_FRAC fraction bits
    localparam logic [31:0] RST_PRE_DECAY   = 32'd1043346;
    localparam logic [31:0] RST_SLOW_DECAY  = 32'd1047528;
    localparam logic [31:0] RST_FAST_DECAY  = 32'd1043346;
    localparam logic [31:0] RST_LTP_GAIN    = 32'd5243;
    localparam logic [31:0] RST_LTD_GAIN    = 32'd5243;
    localparam logic [31:0] RST_HETERO_GAIN = 32'd52429;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_ROUND
    } tsw_mul_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECAY_PRE,
        ST_DECAY_SLOW,
        ST_DECAY_FAST,
        ST_LTD,
        ST_EMIT,
        ST_LTP_A,
        ST_LTP_B,
        ST_HET_A,
        ST_HET_B,
        ST_HET_C,
        ST_HET_D
    } tsw_state_t;

endpackage

[src/tsw_mul.sv]
// Shared digit-serial fixed-point multiplier: rounds to nearest, ties away
// from zero, and saturates to the signed word. Depends on tsw_pkg.
module tsw_mul
    import tsw_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 20,
    parameter int OP_BITS   = 33
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [OP_BITS-1:0]   op_a,
    input  logic signed [OP_BITS-1:0]   op_b,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] result
);

    localparam int NUM_DIGITS = (OP_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int B_BITS     = NUM_DIGITS * DIGIT_BITS;
    localparam int P_BITS     = OP_BITS + B_BITS;
    localparam int CNT_BITS   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int PP_BITS    = OP_BITS + DIGIT_BITS;

    localparam logic [P_BITS:0] Q_MAX =
        {{(P_BITS + 2 - WORD_BITS){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic [P_BITS:0] Q_NEG_MAX = Q_MAX + (P_BITS + 1)'(1);
    localparam logic [P_BITS:0] HALF = (P_BITS + 1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    tsw_mul_state_t state_reg, state_next;
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic [OP_BITS-1:0]          mag_a_reg, mag_a_next;
    logic [B_BITS-1:0]           mag_b_reg, mag_b_next;
    logic [P_BITS-1:0]           acc_reg, acc_next;
    logic                        neg_reg, neg_next;
    logic                        done_reg, done_next;
    logic signed [WORD_BITS-1:0] result_reg, result_next;

    logic [OP_BITS-1:0]    abs_a, abs_b;
    logic [DIGIT_BITS-1:0] digit;
    logic [PP_BITS-1:0]    partial;
    logic [P_BITS:0]       rounded, quot;
    logic signed [WORD_BITS-1:0] sat_val;

    assign abs_a   = op_a[OP_BITS-1] ? (~op_a + 1'b1) : op_a;
    assign abs_b   = op_b[OP_BITS-1] ? (~op_b + 1'b1) : op_b;
    assign digit   = mag_b_reg[B_BITS-1 -: DIGIT_BITS];
    assign partial = PP_BITS'(mag_a_reg) * PP_BITS'(digit);
    assign rounded = {1'b0, acc_reg} + HALF;
    assign quot    = rounded >> FRAC_BITS;

    always_comb
    begin
        if (!neg_reg)
        begin
            sat_val = (quot > Q_MAX) ? W_MAX : quot[WORD_BITS-1:0];
        end
        else
        begin
            sat_val = (quot > Q_NEG_MAX) ? W_MIN : -quot[WORD_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MUL_IDLE:
            begin
                if (start)
                begin
                    state_next = MUL_RUN;
                end
            end
            MUL_RUN:
            begin
                if (cnt_reg == CNT_BITS'(NUM_DIGITS - 1))
                begin
                    state_next = MUL_ROUND;
                end
            end
            MUL_ROUND:
            begin
                state_next = MUL_IDLE;
            end
            default:
            begin
                state_next = MUL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        mag_a_next  = mag_a_reg;
        mag_b_next  = mag_b_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            MUL_IDLE:
            begin
                if (start)
                begin
                    neg_next   = op_a[OP_BITS-1] ^ op_b[OP_BITS-1];
                    mag_a_next = abs_a;
                    mag_b_next = B_BITS'(abs_b);
                    acc_next   = '0;
                    cnt_next   = '0;
                end
            end
            MUL_RUN:
            begin
                acc_next   = (acc_reg << DIGIT_BITS) + P_BITS'(partial);
                mag_b_next = mag_b_reg << DIGIT_BITS;
                cnt_next   = cnt_reg + 1'b1;
            end
            MUL_ROUND:
            begin
                done_next   = 1'b1;
                result_next = sat_val;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MUL_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[src/triplet_stdp_weight_update.sv]
// Triplet STDP synapse weight update with a heterosynaptic term, top level.
// Depends on tsw_pkg and tsw_mul.
//
//   channel | signals                                  | handshake
//   --------+------------------------------------------+------------------
//   input   | pre_count, post_count                    | in_valid/in_ready
//   output  | spike_multiplicity, spike_weight         | out_valid/out_ready
//   config  | cfg_index, cfg_data                      | cfg_wr_en, no wait
//
// Every multiply runs on the shared tsw_mul, which works through NUM_DIGITS digits
// of 16 bits, NUM_DIGITS being ceil(max(WORD_BITS+1, FRAC_BITS+2) / 16).
// A tick runs 3 to 10 multiplies: the trace decays always, the LTD step with a
// pre spike, and the LTP and heterosynaptic steps with a post spike.
// in_ready is high only while idle. A pending result stalls the sequencer only
// when the next one is ready to load. Reset restores weight 1.0, zero traces
// and the default registers at once.
module triplet_stdp_weight_update
    import tsw_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 20
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  pre_count,
    input  logic [7:0]                  post_count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  spike_multiplicity,
    output logic signed [WORD_BITS-1:0] spike_weight,
    input  logic                        cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [FRAC_BITS:0]          cfg_data
);

    localparam int CFG_BITS = FRAC_BITS + 1;
    localparam int OP_BITS  = (WORD_BITS + 1 > FRAC_BITS + 2) ? WORD_BITS + 1 : FRAC_BITS + 2;
    localparam int X_BITS   = WORD_BITS + 2;
    localparam int CFG_UP   = (FRAC_BITS >= CFG_BASE_FRAC) ? FRAC_BITS - CFG_BASE_FRAC : 0;
    localparam int CFG_DN   = (FRAC_BITS <  CFG_BASE_FRAC) ? CFG_BASE_FRAC - FRAC_BITS : 0;

    localparam logic signed [X_BITS-1:0] ONE_X =
        {{(WORD_BITS + 1 - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    function automatic logic [CFG_BITS-1:0] scale_cfg(input logic [31:0] v);
        logic [63:0] wide;
        wide = ({32'd0, v} << CFG_UP) >> CFG_DN;
        return wide[CFG_BITS-1:0];
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [X_BITS-1:0] v
    );
        logic signed [WORD_BITS-1:0] r;
        if ((v[X_BITS-1:WORD_BITS-1] == '0) || (v[X_BITS-1:WORD_BITS-1] == '1))
        begin
            r = v[WORD_BITS-1:0];
        end
        else
        begin
            r = v[X_BITS-1] ? W_MIN : W_MAX;
        end
        return r;
    endfunction

    tsw_state_t state_reg, state_next;

    logic [CFG_BITS-1:0] pre_decay_reg, slow_decay_reg, fast_decay_reg;
    logic [CFG_BITS-1:0] ltp_gain_reg, ltd_gain_reg, hetero_gain_reg;

    logic signed [WORD_BITS-1:0] weight_reg, weight_next;
    logic signed [WORD_BITS-1:0] pre_reg, pre_next;
    logic signed [WORD_BITS-1:0] slow_reg, slow_next;
    logic signed [WORD_BITS-1:0] fast_reg, fast_next;
    logic signed [WORD_BITS-1:0] tmp_reg, tmp_next;
    logic signed [WORD_BITS-1:0] ltp_reg, ltp_next;
    logic [7:0]                  pre_n_reg, pre_n_next;
    logic [7:0]                  post_n_reg, post_n_next;
    logic                        issued_reg, issued_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  mult_reg, mult_next;
    logic signed [WORD_BITS-1:0] out_weight_reg, out_weight_next;

    logic                        mul_start, mul_done, mul_state, out_load;
    logic signed [OP_BITS-1:0]   op_a, op_b;
    logic signed [WORD_BITS-1:0] mul_result;
    logic signed [WORD_BITS:0]   weight_m1;

    assign weight_m1 = (WORD_BITS + 1)'(weight_reg) - ONE_X[WORD_BITS:0];

    tsw_mul #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .OP_BITS   (OP_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .op_a   (op_a),
        .op_b   (op_b),
        .done   (mul_done),
        .result (mul_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECAY_PRE;
                end
            end
            ST_DECAY_PRE:
            begin
                if (mul_done)
                begin
                    state_next = ST_DECAY_SLOW;
                end
            end
            ST_DECAY_SLOW:
            begin
                if (mul_done)
                begin
                    state_next = ST_DECAY_FAST;
                end
            end
            ST_DECAY_FAST:
            begin
                if (mul_done)
                begin
                    if (pre_n_reg != 8'd0)
                    begin
                        state_next = ST_LTD;
                    end
                    else if (post_n_reg != 8'd0)
                    begin
                        state_next = ST_LTP_A;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LTD:
            begin
                if (mul_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = (post_n_reg != 8'd0) ? ST_LTP_A : ST_IDLE;
                end
            end
            ST_LTP_A:
            begin
                if (mul_done)
                begin
                    state_next = ST_LTP_B;
                end
            end
            ST_LTP_B:
            begin
                if (mul_done)
                begin
                    state_next = ST_HET_A;
                end
            end
            ST_HET_A:
            begin
                if (mul_done)
                begin
                    state_next = ST_HET_B;
                end
            end
            ST_HET_B:
            begin
                if (mul_done)
                begin
                    state_next = ST_HET_C;
                end
            end
            ST_HET_C:
            begin
                if (mul_done)
                begin
                    state_next = ST_HET_D;
                end
            end
            ST_HET_D:
            begin
                if (mul_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        weight_next     = weight_reg;
        pre_next        = pre_reg;
        slow_next       = slow_reg;
        fast_next       = fast_reg;
        tmp_next        = tmp_reg;
        ltp_next        = ltp_reg;
        pre_n_next      = pre_n_reg;
        post_n_next     = post_n_reg;
        mult_next       = mult_reg;
        out_weight_next = out_weight_reg;
        out_load        = 1'b0;
        op_a            = '0;
        op_b            = '0;
        mul_state       = (state_reg != ST_IDLE) && (state_reg != ST_EMIT);
        mul_start       = mul_state && !issued_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pre_n_next  = pre_count;
                    post_n_next = post_count;
                end
            end
            ST_DECAY_PRE:
            begin
                op_a = OP_BITS'(pre_reg);
                op_b = OP_BITS'(pre_decay_reg);
                if (mul_done)
                begin
                    pre_next = mul_result;
                end
            end
            ST_DECAY_SLOW:
            begin
                op_a = OP_BITS'(slow_reg);
                op_b = OP_BITS'(slow_decay_reg);
                if (mul_done)
                begin
                    slow_next = mul_result;
                end
            end
            ST_DECAY_FAST:
            begin
                op_a = OP_BITS'(fast_reg);
                op_b = OP_BITS'(fast_decay_reg);
                if (mul_done)
                begin
                    fast_next = mul_result;
                end
            end
            ST_LTD:
            begin
                op_a = OP_BITS'(ltd_gain_reg);
                op_b = OP_BITS'(fast_reg);
                if (mul_done)
                begin
                    weight_next = sat_word(X_BITS'(weight_reg) - X_BITS'(mul_result));
                    pre_next    = sat_word(X_BITS'(pre_reg) + ONE_X);
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load        = 1'b1;
                    mult_next       = pre_n_reg;
                    out_weight_next = weight_reg;
                end
            end
            ST_LTP_A:
            begin
                op_a = OP_BITS'(ltp_gain_reg);
                op_b = OP_BITS'(pre_reg);
                if (mul_done)
                begin
                    tmp_next = mul_result;
                end
            end
            ST_LTP_B:
            begin
                op_a = OP_BITS'(tmp_reg);
                op_b = OP_BITS'(slow_reg);
                if (mul_done)
                begin
                    ltp_next = mul_result;
                end
            end
            ST_HET_A:
            begin
                op_a = OP_BITS'(hetero_gain_reg);
                op_b = OP_BITS'(weight_m1);
                if (mul_done)
                begin
                    tmp_next = mul_result;
                end
            end
            ST_HET_B, ST_HET_C:
            begin
                op_a = OP_BITS'(tmp_reg);
                op_b = OP_BITS'(fast_reg);
                if (mul_done)
                begin
                    tmp_next = mul_result;
                end
            end
            ST_HET_D:
            begin
                op_a = OP_BITS'(tmp_reg);
                op_b = OP_BITS'(fast_reg);
                if (mul_done)
                begin
                    weight_next = sat_word(X_BITS'(weight_reg) + X_BITS'(ltp_reg)
                                           - X_BITS'(mul_result));
                    slow_next   = sat_word(X_BITS'(slow_reg) + ONE_X);
                    fast_next   = sat_word(X_BITS'(fast_reg) + ONE_X);
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
        issued_next    = mul_done ? 1'b0 : (mul_start ? 1'b1 : issued_reg);
        out_valid_next = (out_valid_reg && !out_ready) || out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            issued_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            weight_reg      <= ONE_X[WORD_BITS-1:0];
            pre_reg         <= '0;
            slow_reg        <= '0;
            fast_reg        <= '0;
            pre_decay_reg   <= scale_cfg(RST_PRE_DECAY);
            slow_decay_reg  <= scale_cfg(RST_SLOW_DECAY);
            fast_decay_reg  <= scale_cfg(RST_FAST_DECAY);
            ltp_gain_reg    <= scale_cfg(RST_LTP_GAIN);
            ltd_gain_reg    <= scale_cfg(RST_LTD_GAIN);
            hetero_gain_reg <= scale_cfg(RST_HETERO_GAIN);
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            weight_reg    <= weight_next;
            pre_reg       <= pre_next;
            slow_reg      <= slow_next;
            fast_reg      <= fast_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_PRE_DECAY:   pre_decay_reg   <= cfg_data;
                    REG_SLOW_DECAY:  slow_decay_reg  <= cfg_data;
                    REG_FAST_DECAY:  fast_decay_reg  <= cfg_data;
                    REG_LTP_GAIN:    ltp_gain_reg    <= cfg_data;
                    REG_LTD_GAIN:    ltd_gain_reg    <= cfg_data;
                    REG_HETERO_GAIN: hetero_gain_reg <= cfg_data;
                    default:         pre_decay_reg   <= pre_decay_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg        <= tmp_next;
        ltp_reg        <= ltp_next;
        pre_n_reg      <= pre_n_next;
        post_n_reg     <= post_n_next;
        mult_reg       <= mult_next;
        out_weight_reg <= out_weight_next;
    end

    assign in_ready           = (state_reg == ST_IDLE);
    assign out_valid          = out_valid_reg;
    assign spike_multiplicity = mult_reg;
    assign spike_weight       = out_weight_reg;

endmodule

[src/tsw_checker.sv]
// Port-level checker for triplet_stdp_weight_update, bound to the top level.
// Depends on triplet_stdp_weight_update_assert.svh.
`include "triplet_stdp_weight_update_assert.svh"

module tsw_port_checker
#(
    parameter int WORD_BITS = 32
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [7:0]                  spike_multiplicity,
    input logic signed [WORD_BITS-1:0] spike_weight
);

    `TSW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "input ready right after an accepted transaction")

    `TSW_ASSERT_NOW(a_result_while_busy, $rose(out_valid), !$past(in_ready),
        "result appeared while the block was idle")

    `TSW_ASSERT_NOW(a_nonzero_multiplicity, $rose(out_valid), spike_multiplicity != 8'd0,
        "result carries a zero spike multiplicity")

    `TSW_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid,
        "output transaction dropped while stalled")

    `TSW_ASSERT_NEXT(a_weight_held, out_valid && !out_ready, $stable(spike_weight),
        "spike weight changed while stalled")

endmodule

bind triplet_stdp_weight_update tsw_port_checker #(
    .WORD_BITS (WORD_BITS)
) u_tsw_port_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .spike_multiplicity (spike_multiplicity),
    .spike_weight       (spike_weight)
);

[tb/tsw_checker.sv]
// Scoreboard for triplet_stdp_weight_update: tracks register writes, predicts the
// forwarded presynaptic spikes and compares them with the output channel.
// Depends on tsw_pkg.
module tsw_checker
    import tsw_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 20
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [7:0]                  pre_count,
    input  logic [7:0]                  post_count,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [7:0]                  spike_multiplicity,
    input  logic signed [WORD_BITS-1:0] spike_weight,
    input  logic                        cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [FRAC_BITS:0]          cfg_data,
    output int                          outstanding,
    output int                          fail_count
);

    localparam longint Q_ONE = longint'(1) << FRAC_BITS;
    localparam longint W_HI  = (longint'(1) << (WORD_BITS - 1)) - 1;
    localparam longint W_LO  = -W_HI - 1;

    typedef struct {
        logic [7:0]                  mult;
        logic signed [WORD_BITS-1:0] weight;
    } spike_rec_t;

    spike_rec_t spike_queue[$];
    spike_rec_t oldest;

    longint weight_q, pre_tr, slow_tr, fast_tr;
    longint pre_decay, slow_decay, fast_decay, ltp_amp, ltd_amp, het_amp;
    int     mismatches;

    function automatic longint sat_word(longint v);
        if (v > W_HI)
            return W_HI;
        if (v < W_LO)
            return W_LO;
        return v;
    endfunction

    // exact product, magnitude rounded half away from zero, then saturated
    function automatic longint q_mul(longint a, longint b);
        logic         neg;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] prod;
        neg  = (a < 0) != (b < 0);
        ma   = (a < 0) ? 128'(-a) : 128'(a);
        mb   = (b < 0) ? 128'(-b) : 128'(b);
        prod = ma * mb + (128'd1 << (FRAC_BITS - 1));
        prod = prod >> FRAC_BITS;
        if (!neg)
            return (prod > 128'(W_HI)) ? W_HI : longint'(prod[63:0]);
        return (prod > 128'(W_HI) + 128'd1) ? W_LO : -longint'(prod[63:0]);
    endfunction

    task automatic advance_synapse(logic [7:0] pre_n, logic [7:0] post_n);
        longint     ltp;
        longint     het;
        spike_rec_t rec;
        pre_tr  = q_mul(pre_tr, pre_decay);
        slow_tr = q_mul(slow_tr, slow_decay);
        fast_tr = q_mul(fast_tr, fast_decay);
        if (pre_n != 0)
        begin
            weight_q   = sat_word(weight_q - q_mul(ltd_amp, fast_tr));
            pre_tr     = sat_word(pre_tr + Q_ONE);
            rec.mult   = pre_n;
            rec.weight = weight_q[WORD_BITS-1:0];
            spike_queue.push_back(rec);
        end
        if (post_n != 0)
        begin
            ltp      = q_mul(q_mul(ltp_amp, pre_tr), slow_tr);
            het      = q_mul(het_amp, weight_q - Q_ONE);
            het      = q_mul(het, fast_tr);
            het      = q_mul(het, fast_tr);
            het      = q_mul(het, fast_tr);
            weight_q = sat_word(weight_q + ltp - het);
            slow_tr  = sat_word(slow_tr + Q_ONE);
            fast_tr  = sat_word(fast_tr + Q_ONE);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_decay   = RST_PRE_DECAY;
            slow_decay  = RST_SLOW_DECAY;
            fast_decay  = RST_FAST_DECAY;
            ltp_amp     = RST_LTP_GAIN;
            ltd_amp     = RST_LTD_GAIN;
            het_amp     = RST_HETERO_GAIN;
            weight_q    = Q_ONE;
            pre_tr      = 0;
            slow_tr     = 0;
            fast_tr     = 0;
            mismatches  = 0;
            spike_queue.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PRE_DECAY:   pre_decay  = cfg_data;
                    REG_SLOW_DECAY:  slow_decay = cfg_data;
                    REG_FAST_DECAY:  fast_decay = cfg_data;
                    REG_LTP_GAIN:    ltp_amp    = cfg_data;
                    REG_LTD_GAIN:    ltd_amp    = cfg_data;
                    REG_HETERO_GAIN: het_amp    = cfg_data;
                    default:         ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (spike_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: mult %0d weight %0d",
                                 spike_multiplicity, spike_weight);
                end
                else
                begin
                    oldest = spike_queue.pop_front();
                    if (oldest.mult !== spike_multiplicity || oldest.weight !== spike_weight)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected mult %0d weight %0d, got mult %0d weight %0d",
                                     oldest.mult, oldest.weight, spike_multiplicity,
                                     spike_weight);
                    end
                end
            end
            if (in_valid && in_ready)
                advance_synapse(pre_count, post_count);
            outstanding <= spike_queue.size();
            fail_count  <= mismatches;
        end
    end

endmodule

[tb/testbench.sv]
// Top of the triplet_stdp_weight_update testbench: clock, reset, tick stimulus,
// register setup, output back-pressure and the verdict.
// Depends on tsw_pkg, triplet_stdp_weight_update and tsw_checker.
module testbench
    import tsw_pkg::*;
();

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 20;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

    localparam logic [FRAC_BITS:0] CFG_FULL  = '1;
    localparam logic [FRAC_BITS:0] CFG_UNITY = 21'd1 << FRAC_BITS;

    localparam int SEGMENTS       = 15;
    localparam int TICKS_PER_SEG  = 50;
    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 80;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [7:0]                  pre_count;
    logic [7:0]                  post_count;
    logic                        out_valid;
    logic                        out_ready;
    logic [7:0]                  spike_multiplicity;
    logic signed [WORD_BITS-1:0] spike_weight;
    logic                        cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [FRAC_BITS:0]          cfg_data;

    int outstanding;
    int fail_count;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    bit hold_request;

    triplet_stdp_weight_update #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .pre_count          (pre_count),
        .post_count         (post_count),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .spike_multiplicity (spike_multiplicity),
        .spike_weight       (spike_weight),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    tsw_checker #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .pre_count          (pre_count),
        .post_count         (post_count),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .spike_multiplicity (spike_multiplicity),
        .spike_weight       (spike_weight),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .outstanding        (outstanding),
        .fail_count         (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random back-pressure, or a long hold when requested
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [FRAC_BITS:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all_regs(logic [FRAC_BITS:0] val);
        write_reg(REG_PRE_DECAY, val);
        write_reg(REG_SLOW_DECAY, val);
        write_reg(REG_FAST_DECAY, val);
        write_reg(REG_LTP_GAIN, val);
        write_reg(REG_LTD_GAIN, val);
        write_reg(REG_HETERO_GAIN, val);
    endtask

    // drain results and let the sequencer finish its tick before touching registers
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_tick(logic [7:0] pre_n, logic [7:0] post_n);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        pre_count  <= pre_n;
        post_count <= post_n;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [7:0] spike_count();
        case ($urandom_range(9))
            0:       return 8'd1;
            1:       return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic random_tick();
        int kind;
        kind = $urandom_range(99);
        if (kind < 35)
            send_tick(spike_count(), 8'd0);
        else if (kind < 60)
            send_tick(8'd0, spike_count());
        else if (kind < 80)
            send_tick(spike_count(), spike_count());
        else
            send_tick(8'd0, 8'd0);
    endtask

    function automatic logic [FRAC_BITS:0] pick_reg(bit is_decay);
        case ($urandom_range(7))
            0:       return '0;
            1:       return CFG_FULL;
            2:       return CFG_UNITY;
            3:       return (FRAC_BITS+1)'($urandom_range(0, int'(CFG_FULL)));
            default:
                if (is_decay)
                    return CFG_UNITY - (FRAC_BITS+1)'($urandom_range(0, 30000));
                else
                    return (FRAC_BITS+1)'($urandom_range(0, 100000));
        endcase
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        pre_count     = '0;
        post_count    = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 8;
        recv_idle_pct = 57;
        hold_request  = 1'b0;
        quiet_cycles  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: field extremes and alternating bit patterns
        send_tick(8'd0, 8'd0);
        send_tick(8'd1, 8'd0);
        send_tick(8'd0, 8'd1);
        send_tick(8'd1, 8'd1);
        send_tick(8'd255, 8'd255);
        send_tick(8'd255, 8'd0);
        send_tick(8'd0, 8'd255);
        send_tick(8'hAA, 8'h55);
        send_tick(8'h55, 8'hAA);
        send_tick(8'd1, 8'd1);

        // spare indexes must be ignored; full-scale registers drive saturation
        wait_quiet();
        write_reg(REG_SPARE_A, (FRAC_BITS+1)'($urandom));
        write_reg(REG_SPARE_B, (FRAC_BITS+1)'($urandom));
        write_all_regs(CFG_FULL);
        send_tick(8'd0, 8'd3);
        send_tick(8'd0, 8'd3);
        send_tick(8'd3, 8'd0);
        send_tick(8'd255, 8'd255);
        send_tick(8'd1, 8'd0);
        send_tick(8'd0, 8'd1);
        send_tick(8'd7, 8'd7);
        send_tick(8'd1, 8'd1);

        wait_quiet();
        write_all_regs('0);
        send_tick(8'd1, 8'd1);
        send_tick(8'd0, 8'd0);
        send_tick(8'd255, 8'd255);
        send_tick(8'd1, 8'd0);
        send_tick(8'd0, 8'd1);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_quiet();
            if (seg < 5)
            begin
                send_idle_pct = 8;
                recv_idle_pct = 57;
            end
            else if (seg < 10)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 8;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_PRE_DECAY, pick_reg(1'b1));
            write_reg(REG_SLOW_DECAY, pick_reg(1'b1));
            write_reg(REG_FAST_DECAY, pick_reg(1'b1));
            write_reg(REG_LTP_GAIN, pick_reg(1'b0));
            write_reg(REG_LTD_GAIN, pick_reg(1'b0));
            write_reg(REG_HETERO_GAIN, pick_reg(1'b0));
            if (seg == 2)
                hold_request = 1'b1;
            repeat (TICKS_PER_SEG) random_tick();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/tsw_pkg.sv
src/tsw_mul.sv
src/triplet_stdp_weight_update.sv
src/tsw_checker.sv
tb/tsw_checker.sv
tb/testbench.sv
